>>> sv/lru_pkg.sv
// Package: shared types and constants for the LRU key-value cache.
package lru_pkg;

   localparam int ENTRIES_DEFAULT     = 16;
   localparam int KEY_WIDTH_DEFAULT   = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int CAP_WIDTH           = 5;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture request word, run compare
      logic update;    // commit lookup result to the store
      logic rsp_load;  // load output register
   } lru_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_full;
   } lru_sts_type;

endpackage

>>> sv/lru_datapath.sv
// Datapath: entry store, parallel key compare, age ranks and output register.
module lru_datapath #(
   parameter int ENTRIES     = lru_pkg::ENTRIES_DEFAULT,
   parameter int KEY_WIDTH   = lru_pkg::KEY_WIDTH_DEFAULT,
   parameter int VALUE_WIDTH = lru_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lru_pkg::lru_cmd_type           cmd,
   output lru_pkg::lru_sts_type           sts,
   input  logic [lru_pkg::CAP_WIDTH-1:0]  capacity,
   input  logic                           req_op,
   input  logic [KEY_WIDTH-1:0]           req_key,
   input  logic [VALUE_WIDTH-1:0]         req_value,
   input  logic                           rsp_take,
   output logic                           rsp_found,
   output logic [VALUE_WIDTH-1:0]         rsp_value
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RW = IW;
   localparam int OW = $clog2(ENTRIES + 1);

   logic [ENTRIES-1:0]     valid_ff, valid_in;
   logic [KEY_WIDTH-1:0]   key_ff   [ENTRIES];
   logic [VALUE_WIDTH-1:0] data_ff  [ENTRIES];
   logic [RW-1:0]          rank_ff  [ENTRIES];
   logic [OW-1:0]          occ_ff, occ_in;

   // Stage 1 registers: request plus compare results.
   logic                   op_ff;
   logic [KEY_WIDTH-1:0]   k_ff;
   logic [VALUE_WIDTH-1:0] v_ff;
   logic [ENTRIES-1:0]     match_ff;

   logic                   full_ff, full_in;
   logic                   found_ff;
   logic [VALUE_WIDTH-1:0] val_ff;

   logic [ENTRIES-1:0] match_c;
   always_comb begin
      for (int i = 0; i < ENTRIES; i++)
         match_c[i] = valid_ff[i] && (key_ff[i] == req_key);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         k_ff     <= req_key;
         v_ff     <= req_value;
         match_ff <= match_c;
      end
   end

   // Decide target entry from the registered compare.
   logic           hit;
   logic [IW-1:0]  hit_idx, free_idx, old_idx, tgt;
   logic           free_any;
   logic [OW-1:0]  eff_cap;
   logic           fill;
   logic [RW-1:0]  tgt_rank;
   logic [VALUE_WIDTH-1:0] hit_data;

   always_comb begin
      hit = 1'b0; hit_idx = '0; free_any = 1'b0; free_idx = '0; old_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin hit = 1'b1; hit_idx = IW'(i); end
         if (!valid_ff[i]) begin free_any = 1'b1; free_idx = IW'(i); end
         if (valid_ff[i] && rank_ff[i] == RW'(occ_ff - OW'(1))) old_idx = IW'(i);
      end
      if (capacity == '0) eff_cap = OW'(1);
      else if (32'(capacity) > ENTRIES) eff_cap = OW'(ENTRIES);
      else eff_cap = OW'(capacity);
      fill = !hit && (occ_ff < eff_cap) && free_any;
      tgt  = hit ? hit_idx : (fill ? free_idx : old_idx);
      tgt_rank = rank_ff[tgt];
      hit_data = data_ff[hit_idx];
   end

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      if (cmd.update && op_ff == lru_pkg::OP_PUT && fill) begin
         valid_in[free_idx] = 1'b1;
         occ_in = occ_ff + OW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
      end
   end

   // Age ranks, keys and data; a get miss leaves the store alone.
   always_ff @(posedge clock) begin
      if (cmd.update && (hit || op_ff == lru_pkg::OP_PUT)) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (IW'(i) == tgt) rank_ff[i] <= '0;
            else if (valid_ff[i] && (fill || rank_ff[i] < tgt_rank))
               rank_ff[i] <= rank_ff[i] + RW'(1);
         end
         if (op_ff == lru_pkg::OP_PUT) begin
            key_ff[tgt]  <= k_ff;
            data_ff[tgt] <= v_ff;
         end
      end
   end

   always_comb begin
      full_in = full_ff;
      if (rsp_take) full_in = 1'b0;
      if (cmd.rsp_load) full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         found_ff <= hit;
         val_ff   <= (hit && op_ff == lru_pkg::OP_GET) ? hit_data : '0;
      end
   end

   assign sts.rsp_full = full_ff;
   assign rsp_found    = found_ff;
   assign rsp_value    = val_ff;

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(ENTRIES)) else $error("occupancy overflow");
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(occ_ff)) else $error("occupancy mismatch");
   a_hit_one: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $onehot0(match_ff)) else $error("duplicate key");
`endif

endmodule

>>> sv/lru_ctrl.sv
// Controller: sequences accept, store update and response.
module lru_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lru_pkg::lru_sts_type sts,
   input  logic                 rsp_stall,
   output lru_pkg::lru_cmd_type cmd,
   output logic                 rsp_take
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_UPD  = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign rsp_take  = sts.rsp_full && !rsp_stall;
   // Output register must be free (or draining) before the update loads it.
   assign req_stall = (state_ff != ST_IDLE) || (sts.rsp_full && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_UPD;
         ST_UPD:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign cmd.load     = accept;
   assign cmd.update   = (state_ff == ST_UPD);
   assign cmd.rsp_load = (state_ff == ST_UPD);

`ifndef SYNTH
   a_upd_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPD |=> state_ff == ST_IDLE) else $error("update stuck");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_IDLE) else $error("load while busy");
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!sts.rsp_full || rsp_take)) else $error("response overwrite");
`endif

endmodule

>>> sv/lru_key_value_cache.sv
// Top level: LRU key-value cache with valid/stall channels and a capacity register.
// A fully associative store of ENTRIES keys with least-recently-used replacement.
// Each request word is a get or a put; exactly one response word (found flag and
// value, value zero unless a get hit) comes back per request, in order. A request
// takes two steps: the first captures it and compares its key against all entries in
// parallel, the second commits the rank, key and data update and loads the output
// register, so no new word is taken until the last one's update is done. The
// capacity register (reset 16, 0 acts as 1, values above ENTRIES act as ENTRIES)
// sets how many entries fill before eviction starts; write it only when idle.
// Reset empties the store.
module lru_key_value_cache #(
   parameter int ENTRIES     = lru_pkg::ENTRIES_DEFAULT,
   parameter int KEY_WIDTH   = lru_pkg::KEY_WIDTH_DEFAULT,
   parameter int VALUE_WIDTH = lru_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [KEY_WIDTH-1:0]          req_lookup_key,
   input  logic [VALUE_WIDTH-1:0]        req_write_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [VALUE_WIDTH-1:0]        rsp_read_value,
   input  logic                          csr_write,
   input  logic [lru_pkg::CAP_WIDTH-1:0] csr_wdata
);

   lru_pkg::lru_cmd_type cmd;
   lru_pkg::lru_sts_type sts;
   logic                 rsp_take;
   logic [lru_pkg::CAP_WIDTH-1:0] cap_ff;

   // Hold the capacity register; reset to 16, the full size at the default ENTRIES.
   always_ff @(posedge clock) begin
      if (reset) cap_ff <= lru_pkg::CAP_WIDTH'(16);
      else if (csr_write) cap_ff <= csr_wdata;
   end

   lru_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .sts, .rsp_stall, .cmd, .rsp_take
   );

   lru_datapath #(
      .ENTRIES(ENTRIES), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dp (
      .clock, .reset, .cmd, .sts, .capacity(cap_ff),
      .req_op, .req_key(req_lookup_key), .req_value(req_write_value),
      .rsp_take, .rsp_found, .rsp_value(rsp_read_value)
   );

   assign rsp_valid = sts.rsp_full;

`ifndef SYNTH
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found))
      else $error("response dropped");
   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall) else $error("accept while blocked");
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_read_value == '0) else $error("miss value");
`endif

endmodule

>>> bench/tb.sv
// Testbench for the LRU key-value cache: predicts each response word and checks it in order.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES = 16;
   localparam int KW      = 16;
   localparam int VW      = 32;

   typedef struct {
      logic          found;
      logic [VW-1:0] value;
   } lookup_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_op = lru_pkg::OP_GET;
   logic [KW-1:0]                 req_lookup_key = '0;
   logic [VW-1:0]                 req_write_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_found;
   logic [VW-1:0]                 rsp_read_value;
   logic                          csr_write = 1'b0;
   logic [lru_pkg::CAP_WIDTH-1:0] csr_wdata = '0;

   lru_key_value_cache u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_lookup_key(req_lookup_key), .req_write_value(req_write_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_found(rsp_found),
      .rsp_read_value(rsp_read_value), .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the store: valid bits, keys, data, age ranks (0 = newest).
   logic                          shadow_valid [ENTRIES];
   logic [KW-1:0]                 shadow_key   [ENTRIES];
   logic [VW-1:0]                 shadow_data  [ENTRIES];
   int unsigned                   shadow_rank  [ENTRIES];
   int unsigned                   shadow_count;
   logic [lru_pkg::CAP_WIDTH-1:0] shadow_capacity;

   lookup_result_type pending_results[$];
   int  mismatch_count = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  hit_count = 0;
   int  evict_count = 0;
   bit  hold_rsp = 1'b0;       // long receiver hold-off request
   bit  rsp_random_idle = 1'b1;
   bit  req_random_idle = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("timeout: %0d words still expected", pending_results.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Make one entry the newest; every valid entry newer than it ages by one.
   function automatic void promote_entry(int idx);
      int unsigned r;
      r = shadow_rank[idx];
      for (int i = 0; i < ENTRIES; i++)
         if (shadow_valid[i] && i != idx && shadow_rank[i] < r) shadow_rank[i]++;
      shadow_rank[idx] = 0;
   endfunction

   function automatic void clear_shadow();
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_key[i]   = '0;
         shadow_data[i]  = '0;
         shadow_rank[i]  = 0;
      end
      shadow_count    = 0;
      shadow_capacity = 5'd16;
   endfunction

   // Work out the response to one request word and update the shadow store.
   function automatic lookup_result_type predict_lookup(logic op, logic [KW-1:0] key,
                                                        logic [VW-1:0] value);
      lookup_result_type res;
      int hit, slot, victim;
      int unsigned cap;
      hit = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (hit < 0 && shadow_valid[i] && shadow_key[i] == key) hit = i;
      res.found = (hit >= 0);
      res.value = '0;
      if (hit >= 0) hit_count++;
      if (op == lru_pkg::OP_GET) begin
         if (hit >= 0) begin
            res.value = shadow_data[hit];
            promote_entry(hit);
         end
         return res;
      end
      if (hit >= 0) begin
         shadow_data[hit] = value;
         promote_entry(hit);
         return res;
      end
      cap = shadow_capacity;
      if (cap < 1) cap = 1;
      if (cap > ENTRIES) cap = ENTRIES;
      if (shadow_count < cap) begin
         slot = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !shadow_valid[i]) slot = i;
         if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
               if (shadow_valid[i]) shadow_rank[i]++;
            shadow_valid[slot] = 1'b1;
            shadow_key[slot]   = key;
            shadow_data[slot]  = value;
            shadow_rank[slot]  = 0;
            shadow_count++;
            return res;
         end
      end
      // Evict the oldest valid entry and reuse it.
      victim = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
            victim = i;
      if (victim >= 0) begin
         shadow_key[victim]  = key;
         shadow_data[victim] = value;
         promote_entry(victim);
         evict_count++;
      end
      return res;
   endfunction

   // Offer one request word; hold it until accepted, then record its expected response.
   // Valid stays up after the accept; the next word or a pause takes it over.
   task automatic send_word(logic op, logic [KW-1:0] key, logic [VW-1:0] value);
      int gap;
      gap = 0;
      if (req_random_idle) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if ($urandom_range(0, 1)) gap = 0;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_lookup_key  <= key;
      req_write_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(predict_lookup(op, key, value));
      words_sent++;
   endtask

   // Drop valid, wait until every expected response has come, then let the pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [lru_pkg::CAP_WIDTH-1:0] cap);
      drain_results();
      csr_write <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_write <= 1'b0;
      shadow_capacity = cap;
   endtask

   // Receiver: stall at random, or hold off for a long stretch when asked.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (60) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = rsp_random_idle ? $urandom_range(0, 18) : 0;
         if ($urandom_range(0, 2) == 0) gap = 0;
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Checker: compare each accepted response word with the oldest expectation.
   always @(posedge clock) begin
      lookup_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response word: found=%0b value=%h",
                        rsp_found, rsp_read_value);
         end else begin
            exp_res = pending_results.pop_front();
            words_checked++;
            if (rsp_found !== exp_res.found || rsp_read_value !== exp_res.value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at word %0d: expected found=%0b value=%h, got found=%0b value=%h",
                           words_checked, exp_res.found, exp_res.value, rsp_found,
                           rsp_read_value);
            end
         end
      end
   end

   // Directed: key and value extremes, both operations, hits and misses.
   task automatic test_extremes();
      send_word(lru_pkg::OP_GET, 16'h0000, 32'h0);
      send_word(lru_pkg::OP_PUT, 16'h0000, 32'h7FFF_FFFF);
      send_word(lru_pkg::OP_PUT, 16'hFFFF, 32'h8000_0000);
      send_word(lru_pkg::OP_GET, 16'h0000, 32'hFFFF_FFFF);
      send_word(lru_pkg::OP_GET, 16'hFFFF, 32'h0);
      send_word(lru_pkg::OP_PUT, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(lru_pkg::OP_GET, 16'hFFFF, 32'h0);
      send_word(lru_pkg::OP_PUT, 16'h5A5A, 32'h0);
      send_word(lru_pkg::OP_GET, 16'h5A5A, 32'h1234_5678);
      send_word(lru_pkg::OP_GET, 16'hA5A5, 32'h0);
   endtask

   // Directed: fill past capacity, check oldest is evicted, then capacity extremes.
   task automatic test_eviction();
      for (int i = 0; i < 18; i++)
         send_word(lru_pkg::OP_PUT, KW'(16'h1000 + i), VW'(32'h100 + i));
      send_word(lru_pkg::OP_GET, 16'h1000, 32'h0);
      send_word(lru_pkg::OP_GET, 16'h1011, 32'h0);
      write_capacity(5'd0);           // zero acts as one
      send_word(lru_pkg::OP_PUT, 16'h2000, 32'h2);
      send_word(lru_pkg::OP_GET, 16'h1011, 32'h0);
      write_capacity(5'd31);          // above range acts as full size
      send_word(lru_pkg::OP_PUT, 16'h2001, 32'h3);
      write_capacity(5'd1);
      send_word(lru_pkg::OP_PUT, 16'h2002, 32'h4);
      send_word(lru_pkg::OP_GET, 16'h2001, 32'h0);
   endtask

   // Random pass over a key pool small enough to give frequent hits.
   task automatic test_random(int count, int pool);
      logic [KW-1:0] key;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) key = KW'($urandom_range(0, 16'hFFFF));
         else key = KW'(16'h3000 + $urandom_range(0, pool - 1));
         send_word(1'($urandom_range(0, 1)), key, $urandom);
      end
   endtask

   // Long receiver hold-off while the sender keeps offering words.
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      req_random_idle = 1'b0;
      test_random(40, 20);
      req_random_idle = 1'b1;
      drain_results();             // sender pauses until all responses are in
   endtask

   // Capacity sweep with random traffic; no idling in one phase.
   task automatic test_capacity_sweep();
      logic [lru_pkg::CAP_WIDTH-1:0] caps [6] = '{5'd16, 5'd2, 5'd8, 5'd1, 5'd15, 5'd16};
      foreach (caps[i]) begin
         write_capacity(caps[i]);
         if (i == 2) begin
            req_random_idle = 1'b0;
            rsp_random_idle = 1'b0;
         end
         test_random(240, caps[i] + 6);
         req_random_idle = 1'b1;
         rsp_random_idle = 1'b1;
      end
      write_capacity(5'd0);
      test_random(160, 4);
   endtask

   initial begin
      clear_shadow();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_eviction();
      write_capacity(5'd16);
      test_backpressure();
      test_capacity_sweep();
      drain_results();
      repeat (20) @(posedge clock);
      $display("sent %0d request words, checked %0d responses", words_sent, words_checked);
      $display("hits %0d, evictions %0d, capacities from zero to out of range",
               hit_count, evict_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d left over", mismatch_count, pending_results.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/lru_pkg.sv
sv/lru_datapath.sv
sv/lru_ctrl.sv
sv/lru_key_value_cache.sv
bench/tb.sv
